[design/bbdr_pkg.sv]
// Shared constants, codes and control structs of the box blur downscaler.
`default_nettype none
package bbdr_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int RADIUS = 3;
   localparam int SPAN = 2 * RADIUS + 1;
   localparam int AREA = SPAN * SPAN;
   localparam int MAX_DIM = 2048;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CRD_W = 11;
   localparam int DIM_W = 12;
   localparam int PIX_W = 24;
   localparam int SPAN_W = $clog2(SPAN);
   localparam int SUM_W = $clog2(AREA * 255 + 1);
   localparam int LANE_SUM_W = $clog2(SPAN * 255 + 1);
   localparam int PEND_W = $clog2(MAX_WIDTH * MAX_DIM + 1);
   localparam int NUM_W = CRD_W + DIM_W;
   localparam int THR_W = DIM_W + 3;

   // Reciprocal of the window area, exact for every reachable window sum.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP = ((1 << RECIP_SHIFT) + AREA - 1) / AREA;
   localparam int RECIP_W = $clog2(RECIP + 1);

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   localparam logic [3:0] REG_FRAME_WIDTH = 4'd0;
   localparam logic [3:0] REG_FRAME_HEIGHT = 4'd1;
   localparam logic [3:0] REG_DEST_WIDTH = 4'd2;
   localparam logic [3:0] REG_DEST_HEIGHT = 4'd3;

   typedef struct packed {
      logic en;
      logic [SPAN_W-1:0] bank;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } lane_wr_type;

   typedef struct packed {
      logic en;
      logic [COL_W-1:0] addr;
   } lane_rd_type;

   typedef struct packed {
      logic load;
      logic first;
      logic pass;
      logic [SPAN_W-1:0] bank;
   } merge_ctl_type;

endpackage
`default_nettype wire

[design/bbdr_if.sv]
// Channel interfaces: pixel request, filtered result and register write.
`default_nettype none
interface bbdr_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, action, red_in, green_in, blue_in, input ready);
   modport sink (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface bbdr_rsp_if;
   logic valid;
   logic ready;
   logic [10:0] dest_x;
   logic [10:0] dest_y;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic last_of_frame;
   modport source (output valid, dest_x, dest_y, red_out, green_out, blue_out,
                   last_of_frame, input ready);
   modport sink (input valid, dest_x, dest_y, red_out, green_out, blue_out,
                 last_of_frame, output ready);
endinterface

interface bbdr_csr_if;
   logic valid;
   logic ready;
   logic [3:0] index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/bbdr_lane.sv]
// One row bank of the line store with its write select and registered read.
`default_nettype none
module bbdr_lane
   import bbdr_pkg::*;
(
   input wire logic clock,
   input wire logic [SPAN_W-1:0] bank_id,
   input wire lane_wr_type wr,
   input wire lane_rd_type rd,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [MAX_WIDTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en && wr.bank == bank_id) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/bbdr_merge.sv]
// Adds the lane columns into window sums and scales them by the window area.
`default_nettype none
module bbdr_merge
   import bbdr_pkg::*;
(
   input wire logic clock,
   input wire merge_ctl_type ctl,
   input wire logic [PIX_W-1:0] lane_data [SPAN],
   output logic [7:0] red,
   output logic [7:0] green,
   output logic [7:0] blue
);

   logic [LANE_SUM_W-1:0] col_sum [3];
   logic [SUM_W-1:0] acc_ff [3];
   logic [SUM_W-1:0] acc_in [3];
   logic [SUM_W+RECIP_W-1:0] prod_ff [3];
   logic [PIX_W-1:0] pass_pix_ff;
   logic pass_ff;
   logic [7:0] mean [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         col_sum[ch] = '0;
         for (int k = 0; k < SPAN; k++) begin
            col_sum[ch] = col_sum[ch]
                        + LANE_SUM_W'(lane_data[k][PIX_W-8*(ch+1) +: 8]);
         end
         acc_in[ch] = ctl.first ? SUM_W'(col_sum[ch])
                                : acc_ff[ch] + SUM_W'(col_sum[ch]);
         mean[ch] = prod_ff[ch][RECIP_SHIFT +: 8];
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (ctl.load) begin
            acc_ff[ch] <= acc_in[ch];
         end
         prod_ff[ch] <= (SUM_W+RECIP_W)'(acc_ff[ch]) * (SUM_W+RECIP_W)'(RECIP);
      end
      if (ctl.load) begin
         pass_pix_ff <= lane_data[ctl.bank];
         pass_ff <= ctl.pass;
      end
   end

   assign red = pass_ff ? pass_pix_ff[23:16] : mean[0];
   assign green = pass_ff ? pass_pix_ff[15:8] : mean[1];
   assign blue = pass_ff ? pass_pix_ff[7:0] : mean[2];

endmodule
`default_nettype wire

[design/bbdr_div.sv]
// Restoring divider for destination coordinates, one quotient bit per cycle.
`default_nettype none
module bbdr_div
   import bbdr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [NUM_W-1:0] numer,
   input wire logic [DIM_W-1:0] denom,
   output logic [CRD_W-1:0] quot,
   output logic busy
);

   logic [DIM_W-1:0] rem_ff;
   logic [CRD_W-1:0] bits_ff;
   logic [CRD_W-1:0] quot_ff;
   logic [DIM_W-1:0] denom_ff;
   logic [3:0] cnt_ff;
   logic [DIM_W:0] trial;
   logic fits;

   assign trial = {rem_ff, bits_ff[CRD_W-1]};
   assign fits = trial >= {1'b0, denom_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= 4'(CRD_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 4'd1;
      end
      if (start) begin
         // The quotient stays below the destination size, so the top bits
         // already lie below the divisor.
         rem_ff <= numer[NUM_W-1:CRD_W];
         bits_ff <= numer[CRD_W-1:0];
         denom_ff <= denom;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? DIM_W'(trial - {1'b0, denom_ff}) : trial[DIM_W-1:0];
         bits_ff <= {bits_ff[CRD_W-2:0], 1'b0};
         quot_ff <= {quot_ff[CRD_W-2:0], fits};
      end
   end

   assign quot = quot_ff;
   assign busy = cnt_ff != '0;

endmodule
`default_nettype wire

[design/box_blur_downscale_rgb.sv]
// Top level: 7x7 box blur of an RGB888 raster stream with destination coordinates.
//
// Pixels enter on req_ch in raster order (action 0); action 1 is a flush beat
// that drains one pending result after the frame's last pixel. Each result on
// rsp_ch carries the blurred pixel (or the unchanged pixel near an edge), its
// nearest-neighbour destination coordinate and a flag on the frame's last one.
// Results lag the input by three rows and three pixels of the frame.
// Registers are written through csr_ch; the user must write them only while the
// block is idle, which the block itself does not enforce; csr_ch is always ready.
// A beat that yields no result leaves the block idle. A beat that yields a
// result moves it to ST_RUN, in which the seven row banks are read and merged
// and which ends only once the 11-step coordinate dividers are done, and then
// to ST_SEND, which loads the output register; req_ch is not ready until then.
// The result sits in an output register; a new beat is taken while it waits,
// but the next result stalls the block until rsp_ch takes the previous one.
// Reset restores the default sizes and clears all counters; the line store is
// not cleared and needs no time after reset.
`default_nettype none
module box_blur_downscale_rgb
   import bbdr_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   bbdr_req_if.sink req_ch,
   bbdr_rsp_if.source rsp_ch,
   bbdr_csr_if.sink csr_ch
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_SEND} state_type;

   localparam logic [3:0] LAST_READ = 4'(SPAN - 1);
   localparam logic [3:0] RESULT_STEP = 4'(SPAN + 2);

   state_type state_ff;
   logic [3:0] step_ff;

   logic [DIM_W-1:0] frame_width_ff, frame_height_ff, dest_width_ff, dest_height_ff;
   logic [DIM_W-1:0] w, h, dw, dh;

   logic [CRD_W-1:0] in_col_ff, in_row_ff, out_col_ff, out_row_ff;
   logic [SPAN_W-1:0] in_bank_ff, out_bank_ff;
   logic [PEND_W-1:0] pending_ff;
   logic frame_rcv_ff;

   logic [CRD_W-1:0] base_ff;
   logic [SPAN_W-1:0] row_bank_ff;
   logic interior_ff, last_ff;

   logic [CRD_W-1:0] dest_x_ff, dest_y_ff;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic last_out_ff, rsp_valid_ff;

   logic accept, pix, emit, interior, last, col_wrap, row_wrap;
   logic [PEND_W-1:0] pend_inc;
   logic [THR_W-1:0] thr;

   lane_wr_type wr;
   lane_rd_type rd;
   merge_ctl_type mctl_ff;
   logic [PIX_W-1:0] lane_data [SPAN];
   logic [7:0] m_red, m_green, m_blue;
   logic [CRD_W-1:0] qx, qy;
   logic busy_x, busy_y;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      else r = v;
      return r;
   endfunction

   assign w = clamp_dim(frame_width_ff);
   assign h = clamp_dim(frame_height_ff);
   assign dw = clamp_dim(dest_width_ff);
   assign dh = clamp_dim(dest_height_ff);

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = state_ff == ST_IDLE;
   assign accept = req_ch.valid && state_ff == ST_IDLE;

   always_comb begin
      pix = accept && req_ch.action == ACT_PIXEL && !frame_rcv_ff;
      pend_inc = pending_ff + PEND_W'(pix);
      thr = THR_W'(RADIUS) * THR_W'(w) + THR_W'(RADIUS);
      emit = accept && ((req_ch.action == ACT_FLUSH && pending_ff != '0)
                        || (pix && pend_inc > PEND_W'(thr)));
      interior = out_col_ff >= CRD_W'(RADIUS)
               && {1'b0, out_col_ff} + DIM_W'(RADIUS) < w
               && out_row_ff >= CRD_W'(RADIUS)
               && {1'b0, out_row_ff} + DIM_W'(RADIUS) < h;
      col_wrap = {1'b0, out_col_ff} + DIM_W'(1) >= w;
      row_wrap = {1'b0, out_row_ff} + DIM_W'(1) >= h;
      last = col_wrap && row_wrap;
   end

   assign wr.en = pix;
   assign wr.bank = in_bank_ff;
   assign wr.addr = in_col_ff;
   assign wr.data = {req_ch.red_in, req_ch.green_in, req_ch.blue_in};

   assign rd.en = state_ff == ST_RUN && step_ff <= LAST_READ;
   assign rd.addr = interior_ff ? base_ff + COL_W'(step_ff) : base_ff;

   for (genvar k = 0; k < SPAN; k++) begin : g_lane
      bbdr_lane u_lane (
         .clock(clock),
         .bank_id(SPAN_W'(k)),
         .wr(wr),
         .rd(rd),
         .rd_data(lane_data[k])
      );
   end

   bbdr_merge u_merge (
      .clock(clock),
      .ctl(mctl_ff),
      .lane_data(lane_data),
      .red(m_red),
      .green(m_green),
      .blue(m_blue)
   );

   bbdr_div u_div_x (
      .clock(clock),
      .reset(reset),
      .start(emit),
      .numer(NUM_W'(out_col_ff) * NUM_W'(dw)),
      .denom(w),
      .quot(qx),
      .busy(busy_x)
   );

   bbdr_div u_div_y (
      .clock(clock),
      .reset(reset),
      .start(emit),
      .numer(NUM_W'(out_row_ff) * NUM_W'(dh)),
      .denom(h),
      .quot(qy),
      .busy(busy_y)
   );

   always_ff @(posedge clock) begin
      mctl_ff.load <= rd.en;
      mctl_ff.first <= step_ff == '0;
      mctl_ff.pass <= !interior_ff;
      mctl_ff.bank <= row_bank_ff;
      if (emit) begin
         base_ff <= interior ? out_col_ff - CRD_W'(RADIUS) : out_col_ff;
         row_bank_ff <= out_bank_ff;
         interior_ff <= interior;
         last_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= DIM_W'(640);
         frame_height_ff <= DIM_W'(480);
         dest_width_ff <= DIM_W'(320);
         dest_height_ff <= DIM_W'(240);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FRAME_WIDTH: frame_width_ff <= csr_ch.data;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_ch.data;
            REG_DEST_WIDTH: dest_width_ff <= csr_ch.data;
            REG_DEST_HEIGHT: dest_height_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_bank_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_bank_ff <= '0;
         pending_ff <= '0;
         frame_rcv_ff <= 1'b0;
      end else begin
         if (pix) begin
            if ({1'b0, in_col_ff} + DIM_W'(1) >= w) begin
               in_col_ff <= '0;
               if ({1'b0, in_row_ff} + DIM_W'(1) >= h) begin
                  in_row_ff <= '0;
                  in_bank_ff <= '0;
                  frame_rcv_ff <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + CRD_W'(1);
                  in_bank_ff <= in_bank_ff == SPAN_W'(SPAN - 1) ? '0
                                                               : in_bank_ff + SPAN_W'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + CRD_W'(1);
            end
         end
         if (emit) begin
            if (col_wrap) begin
               out_col_ff <= '0;
               if (row_wrap) begin
                  out_row_ff <= '0;
                  out_bank_ff <= '0;
               end else begin
                  out_row_ff <= out_row_ff + CRD_W'(1);
                  out_bank_ff <= out_bank_ff == SPAN_W'(SPAN - 1) ? '0
                                                                 : out_bank_ff + SPAN_W'(1);
               end
            end else begin
               out_col_ff <= out_col_ff + CRD_W'(1);
            end
         end
         // The frame's last result starts a new frame on the input side.
         if (emit && last) begin
            pending_ff <= '0;
            frame_rcv_ff <= 1'b0;
            in_col_ff <= '0;
            in_row_ff <= '0;
            in_bank_ff <= '0;
         end else if (emit) begin
            pending_ff <= pend_inc - PEND_W'(1);
         end else begin
            pending_ff <= pend_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_SEND) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (emit) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (step_ff >= RESULT_STEP && !busy_x && !busy_y) begin
                  state_ff <= ST_SEND;
               end else begin
                  step_ff <= step_ff + 4'd1;
               end
            end
            ST_SEND: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  dest_x_ff <= qx;
                  dest_y_ff <= qy;
                  red_ff <= m_red;
                  green_ff <= m_green;
                  blue_ff <= m_blue;
                  last_out_ff <= last_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dest_x = dest_x_ff;
   assign rsp_ch.dest_y = dest_y_ff;
   assign rsp_ch.red_out = red_ff;
   assign rsp_ch.green_out = green_ff;
   assign rsp_ch.blue_out = blue_ff;
   assign rsp_ch.last_of_frame = last_out_ff;

endmodule
`default_nettype wire
